/* sv/mads_pkg.sv */
// Package for the median absolute deviation sum block: sizes and types.
package mads_pkg;
	localparam int MaxItems = 4096;
	localparam int AddrW = $clog2(MaxItems);
	localparam int CountW = $clog2(MaxItems + 1);
	localparam int SumW = 44;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW = 1;

	// Front-to-back command: store one value unless the store is full, optionally finish the set
	typedef struct packed {
		logic [31:0] sample;
		logic        store;
		logic        final_item;
		logic        overflowed;
	} cmd_t;

	typedef struct packed {
		logic [31:0]     median_value;
		logic [SumW-1:0] deviation_sum;
		logic            overflowed;
	} res_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_SUM,
		ST_SUM_DRAIN,
		ST_OUT
	} back_state_t;
endpackage

/* sv/mads_stream_if.sv */
// Valid/ready channel interface carrying a payload of parameterized type.
interface mads_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/mads_front.sv */
// Front end: counts stored values, flags overflow and queues commands.
module mads_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            sample,
	input  logic                   final_item,
	input  logic                   in_valid,
	output logic                   in_ready,
	output mads_pkg::cmd_t         cmd,
	output logic                   cmd_valid,
	input  logic                   cmd_ready
);
	logic [mads_pkg::CountW-1:0] count_q;
	logic                        ovf_q;
	mads_pkg::cmd_t              fifo_q [mads_pkg::QueueDepth];
	logic [mads_pkg::QueuePtrW-1:0] wr_q, rd_q;
	logic [mads_pkg::QueuePtrW:0] fill_q;
	logic push, pop, full;

	assign full = (fill_q == (mads_pkg::QueuePtrW+1)'(mads_pkg::QueueDepth));
	assign in_ready = !full;
	assign push = in_valid && in_ready;
	assign cmd_valid = (fill_q != '0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = fifo_q[rd_q];

	// Classify and track the set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				if (final_item) begin
					count_q <= '0;
					ovf_q <= 1'b0;
				end else if (count_q < mads_pkg::CountW'(mads_pkg::MaxItems)) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				wr_q <= wr_q + 1'b1;
			end
			if (pop) rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + (mads_pkg::QueuePtrW+1)'(push) - (mads_pkg::QueuePtrW+1)'(pop);
		end
	end

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].sample <= sample;
			fifo_q[wr_q].store <= (count_q < mads_pkg::CountW'(mads_pkg::MaxItems));
			fifo_q[wr_q].final_item <= final_item;
			fifo_q[wr_q].overflowed <= ovf_q ||
				(count_q >= mads_pkg::CountW'(mads_pkg::MaxItems));
		end
	end
endmodule

/* sv/mads_back.sv */
// Back end: stores values, selects the median bit by bit, sums deviations.
module mads_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mads_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output mads_pkg::res_t res,
	output logic           res_valid,
	input  logic           res_ready
);
	localparam int AW = mads_pkg::AddrW;
	localparam int CW = mads_pkg::CountW;
	localparam int SW = mads_pkg::SumW;

	logic [31:0] mem_q [mads_pkg::MaxItems];
	logic [31:0] rdata_s1;
	logic        rvalid_s1;

	mads_pkg::back_state_t state_q, state_d;
	logic [CW-1:0] n_q, idx_q, k_q, zeros_q;
	logic [31:0]   prefix_q, mask_q;
	logic [4:0]    bit_q;
	logic [SW-1:0] sum_q;
	logic          ovf_q;
	logic          res_valid_q;
	mads_pkg::res_t res_q;

	logic          mem_we, mem_re, last_idx;
	logic [CW-1:0] n_next;
	logic [31:0]   bmask, diff;
	logic [SW:0]   sum_add;
	logic          hit;
	logic [CW-1:0] zeros_tot;

	assign n_next = n_q + CW'(cmd.store);
	assign bmask = 32'd1 << bit_q;
	assign last_idx = (idx_q == n_q - 1'b1);
	assign diff = (rdata_s1 > prefix_q) ? rdata_s1 - prefix_q : prefix_q - rdata_s1;
	assign sum_add = {1'b0, sum_q} + (SW+1)'(diff);

	// Count values under the prefix with the current bit clear
	assign hit = rvalid_s1 && ((rdata_s1 & mask_q) == prefix_q) &&
		((rdata_s1 & bmask) == 32'd0);
	assign zeros_tot = zeros_q + CW'(hit);

	// Sequence the passes
	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		unique case (state_q)
			mads_pkg::ST_LOAD: begin
				cmd_ready = 1'b1;
				mem_we = cmd_valid && cmd.store;
				if (cmd_valid && cmd.final_item) state_d = mads_pkg::ST_SCAN;
			end
			mads_pkg::ST_SCAN: begin
				mem_re = 1'b1;
				if (last_idx) state_d = mads_pkg::ST_DRAIN;
			end
			mads_pkg::ST_DRAIN: begin
				state_d = (bit_q == 5'd0) ? mads_pkg::ST_SUM : mads_pkg::ST_SCAN;
			end
			mads_pkg::ST_SUM: begin
				mem_re = 1'b1;
				if (last_idx) state_d = mads_pkg::ST_SUM_DRAIN;
			end
			mads_pkg::ST_SUM_DRAIN: state_d = mads_pkg::ST_OUT;
			// Hold the new result until the previous one is taken
			mads_pkg::ST_OUT: if (!res_valid_q) state_d = mads_pkg::ST_LOAD;
			default: state_d = mads_pkg::ST_LOAD;
		endcase
	end

	// Store and read values
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[n_q[AW-1:0]] <= cmd.sample;
		rdata_s1 <= mem_q[idx_q[AW-1:0]];
	end

	// Advance passes and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mads_pkg::ST_LOAD;
			n_q <= '0;
			idx_q <= '0;
			rvalid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvalid_s1 <= mem_re;
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (mem_re) idx_q <= last_idx ? '0 : idx_q + 1'b1;
			unique case (state_q)
				mads_pkg::ST_LOAD: begin
					if (cmd_valid && cmd_ready) begin
						n_q <= n_next;
						ovf_q <= cmd.overflowed;
						if (cmd.final_item) begin
							k_q <= n_next >> 1;
							prefix_q <= '0;
							mask_q <= '0;
							bit_q <= 5'd31;
							zeros_q <= '0;
							idx_q <= '0;
						end
					end
				end
				mads_pkg::ST_SCAN: begin
					if (hit) zeros_q <= zeros_tot;
				end
				mads_pkg::ST_DRAIN: begin
					if (k_q >= zeros_tot) begin
						k_q <= k_q - zeros_tot;
						prefix_q <= prefix_q | bmask;
					end
					mask_q <= mask_q | bmask;
					zeros_q <= '0;
					bit_q <= bit_q - 1'b1;
					sum_q <= '0;
				end
				mads_pkg::ST_SUM, mads_pkg::ST_SUM_DRAIN: begin
					if (rvalid_s1) sum_q <= sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
				end
				mads_pkg::ST_OUT: begin
					if (!res_valid_q) begin
						res_q.median_value <= prefix_q;
						res_q.deviation_sum <= sum_q;
						res_q.overflowed <= ovf_q;
						res_valid_q <= 1'b1;
						n_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;
endmodule

/* sv/median_abs_deviation_sum_top.sv */
// Top level: sum of absolute deviations from the upper median of a set.
// Loading: one item per cycle through a two-entry command queue, while the queue has room.
// After the final item: 32 selection passes plus a summing pass, each reading
// every stored value through the single memory read port.
// The result sits in an output register while the next set loads; a newer
// result waits in the back end until the older one is taken.
// Reset clears counts and control; the value memory needs no clearing.
module median_abs_deviation_sum_top (
	input  logic        clk,
	input  logic        arst_n,
	mads_stream_if.sink   in_ch,
	mads_stream_if.source out_ch
);
	mads_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_ready;
	mads_pkg::res_t res;

	mads_front u_front (
		.clk, .arst_n,
		.sample(in_ch.data.sample), .final_item(in_ch.data.final_item),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.cmd, .cmd_valid, .cmd_ready
	);

	mads_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.res, .res_valid(out_ch.valid), .res_ready(out_ch.ready)
	);

	assign out_ch.data.median_value = res.median_value;
	assign out_ch.data.deviation_sum = res.deviation_sum;
	assign out_ch.data.overflowed = res.overflowed;

	// Stalled result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while stalled");
	// Input stalls only when the command queue holds items
	a_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> cmd_valid)
		else $error("input stalled with empty command queue");
endmodule

/* tb/sv/median_abs_deviation_sum_top_test.sv */
// Testbench for the median absolute deviation sum block: directed, overflow and random sets.
module median_abs_deviation_sum_top_test;
	typedef struct packed {
		logic [31:0] sample;
		logic        final_item;
	} in_item_t;

	typedef struct {
		logic [31:0]               median_value;
		logic [mads_pkg::SumW-1:0] deviation_sum;
		logic                      overflowed;
	} mad_result_t;

	localparam int WatchdogLimit = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mads_stream_if #(.payload_t(in_item_t)) in_ch ();
	mads_stream_if #(.payload_t(mads_pkg::res_t)) out_ch ();

	median_abs_deviation_sum_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Generate the clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: the loaded set and its flags
	logic [31:0] set_values[$];
	logic        set_overflow;
	mad_result_t expected_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int stall_cycles = 0;
	bit failed = 1'b0;

	// Rank selection by sorting; median is rank n/2
	function automatic mad_result_t compute_mad(input logic [31:0] vals[$], input logic ovf);
		logic [31:0] sorted[$];
		logic [31:0] med;
		logic [63:0] acc;
		mad_result_t r;
		sorted = vals;
		sorted.sort();
		med = sorted[sorted.size() / 2];
		acc = 0;
		foreach (sorted[i]) begin
			acc += (sorted[i] > med) ? (sorted[i] - med) : (med - sorted[i]);
			if (acc > 64'((64'd1 << mads_pkg::SumW) - 1)) begin
				acc = (64'd1 << mads_pkg::SumW) - 1;
			end
		end
		r.median_value = med;
		r.deviation_sum = acc[mads_pkg::SumW-1:0];
		r.overflowed = ovf;
		return r;
	endfunction

	// Advance the predictor by one accepted item
	function automatic void predict_item(input in_item_t it);
		if (set_values.size() < mads_pkg::MaxItems) begin
			set_values = {set_values, it.sample};
		end else begin
			set_overflow = 1'b1;
		end
		if (it.final_item) begin
			expected_results = {expected_results, compute_mad(set_values, set_overflow)};
			set_values.delete();
			set_overflow = 1'b0;
		end
	endfunction

	// Send one item, idling at random beforehand
	task automatic send_item(input logic [31:0] sample, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{sample: sample, final_item: fin};
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
	endtask

	// Hold until every expected result has come
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(15);
			3: return 32'hFFFF_FFF0 | $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++) begin
			send_item(rand_value(), i == n - 1);
		end
	endtask

	// Extremes, single values, even and odd sizes, duplicates
	task automatic test_directed();
		send_item(32'd0, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'd0, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd0, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'd7, 1'b0);
		send_item(32'd7, 1'b0);
		send_item(32'd7, 1'b1);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);
		send_item(32'd3, 1'b0);
		send_item(32'h8000_0000, 1'b1);
	endtask

	// Fill the store past its size so values are dropped
	task automatic test_overflow();
		for (int i = 0; i < mads_pkg::MaxItems + 3; i++) begin
			send_item(i[0] ? 32'hFFFF_FFFF : $urandom, i == mads_pkg::MaxItems + 2);
		end
	endtask

	// Random sets of mostly small sizes
	task automatic test_random(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
			send_set(n);
			sent += n;
			if ($urandom_range(19) == 0) begin
				wait_drained();
			end
		end
	endtask

	// Receiver: stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				failed = 1'b1;
				if (mismatch_count < 10) begin
					$display("unexpected result median=%h sum=%h",
						out_ch.data.median_value, out_ch.data.deviation_sum);
				end
				mismatch_count++;
			end else begin
				mad_result_t e;
				e = expected_results.pop_front();
				if (out_ch.data.median_value !== e.median_value
						|| out_ch.data.deviation_sum !== e.deviation_sum
						|| out_ch.data.overflowed !== e.overflowed) begin
					failed = 1'b1;
					if (mismatch_count < 10) begin
						$display("mismatch exp med=%h sum=%h ovf=%b got med=%h sum=%h ovf=%b",
							e.median_value, e.deviation_sum, e.overflowed,
							out_ch.data.median_value, out_ch.data.deviation_sum,
							out_ch.data.overflowed);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Feed the predictor with accepted items
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			predict_item(in_ch.data);
		end
	end

	// Watchdog on cycles with no item or result accepted
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WatchdogLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		set_overflow = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 79;
		test_directed();
		wait_drained();
		test_random(300);
		send_idle_pct = 79;
		recv_idle_pct = 35;
		test_random(300);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_overflow();
		wait_drained();
		repeat (200) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
